// ===== hdl/qubo_pattern_matrix_element_defines.svh =====
// Assertion macros for the QUBO pattern matrix element.
// Included by modules that check their own pipeline behavior; no other dependencies.
`ifndef QUBO_PATTERN_MATRIX_ELEMENT_DEFINES_SVH
`define QUBO_PATTERN_MATRIX_ELEMENT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define QPME_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define QPME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qpme_pkg.sv =====
// Package for the QUBO pattern matrix element: register indexes, mode codes,
// pattern bit positions and size limits. No dependencies.
package qpme_pkg;

    localparam int unsigned MAX_VARS   = 16;
    localparam int unsigned MAX_DOMAIN = 16;

    localparam int unsigned IDX_W  = 4;
    localparam int unsigned SIZE_W = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_W   = 4 * IDX_W;
    localparam int unsigned ENTRY_W = 32;

    localparam logic [SIZE_W-1:0] DOMAIN_SAT = SIZE_W'(MAX_DOMAIN);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_FLAGS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARIABLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PARAM_VALUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PARAM_GIVEN   = 3'd6;

    // diagonal modes; the spare code behaves as none
    localparam logic [1:0] DIAG_NONE      = 2'd0;
    localparam logic [1:0] DIAG_MINUS_ONE = 2'd1;
    localparam logic [1:0] DIAG_LINEAR    = 2'd2;
    localparam logic [1:0] DIAG_UNUSED    = 2'd3;

    // pattern flag bit positions
    localparam int unsigned PAT_EQUAL       = 0;
    localparam int unsigned PAT_DIFFERENT   = 1;
    localparam int unsigned PAT_GREATER     = 2;
    localparam int unsigned PAT_GREATER_EQ  = 3;
    localparam int unsigned PAT_LESS        = 4;
    localparam int unsigned PAT_LESS_EQ     = 5;
    localparam int unsigned PAT_POS_PEN     = 6;
    localparam int unsigned PAT_POS_REW     = 7;
    localparam int unsigned PAT_NOPOS_PEN   = 8;
    localparam int unsigned PAT_NOPOS_REW   = 9;
    localparam int unsigned PAT_SWAP        = 10;
    localparam int unsigned PAT_REPEL       = 11;
    localparam int unsigned PAT_ATTRACT     = 12;
    localparam int unsigned PAT_LINEAR      = 13;
    localparam int unsigned PAT_W           = 14;

endpackage

// ===== hdl/qubo_pattern_matrix_element.sv =====
// QUBO pattern matrix element: one registered pass from indices to matrix entry.
// Depends on qpme_pkg and qubo_pattern_matrix_element_defines.svh.
//
// Takes one entry address and returns one entry per cycle while m_axis_tready holds.
// Each word goes into an input register, through one 19x9 signed multiplier and a
// 32-bit sum, and into the result register; the input side keeps accepting while
// a result waits as long as the input register is empty. Configuration writes are
// always ready and must be made while no word is in flight.
module qubo_pattern_matrix_element
    import qpme_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // row_var[3:0], row_val[7:4], col_var[11:8], col_val[15:12]
    input  logic [IN_W-1:0]       s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // entry_value[31:0]
    output logic [ENTRY_W-1:0]    m_axis_tdata,
    // entry_valid[0]
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "qubo_pattern_matrix_element_defines.svh"

    // configuration
    logic [1:0]        r_diag_mode;
    logic [PAT_W-1:0]  r_flags;
    logic [SIZE_W-1:0] r_domain;
    logic [SIZE_W-1:0] r_nvars;
    logic [7:0]        r_start;
    logic [15:0]       r_param;
    logic              r_param_given;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag_mode   <= DIAG_NONE;
            r_flags       <= '0;
            r_domain      <= SIZE_W'(1);
            r_nvars       <= SIZE_W'(1);
            r_start       <= '0;
            r_param       <= '0;
            r_param_given <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIAG_MODE:     r_diag_mode   <= i_cfg_data[1:0];
                CFG_PATTERN_FLAGS: r_flags       <= i_cfg_data[PAT_W-1:0];
                CFG_DOMAIN_SIZE:   r_domain      <= i_cfg_data[SIZE_W-1:0];
                CFG_NUM_VARIABLES: r_nvars       <= i_cfg_data[SIZE_W-1:0];
                CFG_START_VALUE:   r_start       <= i_cfg_data[7:0];
                CFG_PARAM_VALUE:   r_param       <= i_cfg_data;
                CFG_PARAM_GIVEN:   r_param_given <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_rv, r_rd, r_cv, r_cd;
    logic             r_out_valid;
    logic [ENTRY_W-1:0] r_out_value;
    logic             r_out_flag;
    logic             adv_out;

    assign adv_out       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || adv_out;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_rv <= s_axis_tdata[IDX_W-1:0];
            r_rd <= s_axis_tdata[2*IDX_W-1:IDX_W];
            r_cv <= s_axis_tdata[3*IDX_W-1:2*IDX_W];
            r_cd <= s_axis_tdata[4*IDX_W-1:3*IDX_W];
        end
    end

    // entry computation
    logic              in_range, upper, valid;
    logic              is_diag, same_var;
    logic [SIZE_W-1:0] ds_sat;
    logic signed [8:0]  a, b;
    logic signed [15:0] p_diag, p_cross;
    logic signed [18:0] mul_x;
    logic signed [8:0]  mul_y;
    logic signed [27:0] prod;
    logic              mul_en;
    logic [IDX_W-1:0]  val_dist;
    logic [16:0]       rep_t, att_t;
    logic [15:0]       rep, att;
    logic              v_eq, v_lt, v_gt, coincide, apart, full_swap, half_swap;
    logic [3:0]        pos_cnt;
    logic [2:0]        neg_cnt;
    logic signed [4:0] pat_sum;
    logic signed [31:0] other;
    logic [ENTRY_W-1:0] n_out_value;

    always_comb begin
        in_range = ({1'b0, r_rv} < r_nvars) && ({1'b0, r_cv} < r_nvars) &&
                   ({1'b0, r_rd} < r_domain) && ({1'b0, r_cd} < r_domain);
        upper    = (r_rv < r_cv) || ((r_rv == r_cv) && (r_rd <= r_cd));
        valid    = in_range && upper;
        same_var = (r_rv == r_cv);
        is_diag  = same_var && (r_rd == r_cd);
        ds_sat   = (r_domain > DOMAIN_SAT) ? DOMAIN_SAT : r_domain;

        a = $signed({5'b0, r_rd} + {r_start[7], r_start});
        b = $signed({5'b0, r_cd} + {r_start[7], r_start});
        p_diag  = r_param_given ? $signed(r_param) : 16'sd1;
        p_cross = r_param_given ? $signed(r_param) : 16'sd0;

        // diagonal uses (a - 2p) * a, the others (2a) * b
        if (is_diag) begin
            mul_x = $signed({{10{a[8]}}, a} - {p_diag[15], p_diag[15], p_diag, 1'b0});
            mul_y = a;
        end else begin
            mul_x = $signed({{9{a[8]}}, a, 1'b0});
            mul_y = b;
        end
        prod   = mul_x * mul_y;
        mul_en = same_var ? (r_diag_mode == DIAG_LINEAR) : r_flags[PAT_LINEAR];

        val_dist = (r_rd > r_cd) ? (r_rd - r_cd) : (r_cd - r_rd);
        rep_t = {p_cross[15], p_cross} - {13'b0, val_dist};
        att_t = {13'b0, val_dist} - {12'b0, ds_sat} + 17'd1 + {p_cross[15], p_cross};
        rep   = (r_flags[PAT_REPEL] && !rep_t[16]) ? rep_t[15:0] : 16'd0;
        att   = (r_flags[PAT_ATTRACT] && !att_t[16]) ? att_t[15:0] : 16'd0;

        v_eq      = (r_rd == r_cd);
        v_lt      = (r_rd < r_cd);
        v_gt      = (r_rd > r_cd);
        coincide  = (r_rv == r_rd) || (r_cv == r_cd);
        apart     = (r_rv != r_rd) && (r_rv != r_cd) && (r_cv != r_rd) && (r_cv != r_cd);
        full_swap = (r_rv == r_cd) && (r_cv == r_rd);
        half_swap = !full_swap && ((r_rv == r_cd) || (r_cv == r_rd));

        pos_cnt = 4'(v_eq && r_flags[PAT_EQUAL])      + 4'(v_eq && r_flags[PAT_GREATER_EQ])
                + 4'(v_eq && r_flags[PAT_LESS_EQ])    + 4'(v_lt && r_flags[PAT_DIFFERENT])
                + 4'(v_lt && r_flags[PAT_LESS])       + 4'(v_lt && r_flags[PAT_LESS_EQ])
                + 4'(v_gt && r_flags[PAT_DIFFERENT])  + 4'(v_gt && r_flags[PAT_GREATER])
                + 4'(v_gt && r_flags[PAT_GREATER_EQ]) + 4'(coincide && r_flags[PAT_POS_REW])
                + 4'(apart && r_flags[PAT_NOPOS_REW]) + 4'(half_swap && r_flags[PAT_SWAP]);
        neg_cnt = 3'(coincide && r_flags[PAT_POS_PEN]) + 3'(apart && r_flags[PAT_NOPOS_PEN])
                + 3'(full_swap && r_flags[PAT_SWAP]);
        pat_sum = $signed({1'b0, pos_cnt}) - $signed({2'b0, neg_cnt});

        priority if (is_diag) begin
            other = (r_diag_mode == DIAG_MINUS_ONE) ? -32'sd1 : 32'sd0;
        end else if (same_var) begin
            other = 32'sd2;
        end else begin
            other = 32'(pat_sum) + $signed({16'b0, rep}) + $signed({16'b0, att});
        end

        if (!valid) begin
            n_out_value = '0;
        end else begin
            n_out_value = ENTRY_W'(other + (mul_en ? 32'(prod) : 32'sd0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_out_value <= n_out_value;
            r_out_flag  <= valid;
        end
    end

    `QPME_ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "invalid entry not zero")
    `QPME_ASSERT_IMPLY(a_no_overrun, i_clk, i_rst_n,
        r_s1_valid && !adv_out, !s_axis_tready, "input register overrun")
    `QPME_ASSERT_NEXT(a_advance, i_clk, i_rst_n,
        r_s1_valid && adv_out, r_out_valid, "word lost between stages")
    `QPME_ASSERT_NEXT(a_diag_minus_one, i_clk, i_rst_n,
        r_s1_valid && adv_out && valid && is_diag && (r_diag_mode == DIAG_MINUS_ONE),
        m_axis_tdata == {ENTRY_W{1'b1}}, "diagonal minus one wrong")

endmodule
